/* hdl/ddc_edid_i2c_reader_unit_assert.svh */
// assertion macros used by the port checker file
`ifndef DDC_EDID_I2C_READER_UNIT_ASSERT_SVH
`define DDC_EDID_I2C_READER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define DDC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ddc edid reader check failed");

// next-cycle implication, checked outside reset
`define DDC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ddc edid reader check failed");

`endif

/* hdl/ddc_edid_pkg.sv */
// shared types and constants of the ddc edid reader
package ddc_edid_pkg;

	localparam int MAX_BYTES = 128;
	localparam int EFF_W = $clog2(MAX_BYTES + 1);

	localparam logic [2:0] REG_ENABLE = 3'd0;
	localparam logic [2:0] REG_ADDRESS = 3'd1;
	localparam logic [2:0] REG_OFFSET = 3'd2;
	localparam logic [2:0] REG_LENGTH = 3'd3;
	localparam logic [2:0] REG_TICKS = 3'd4;

	localparam logic [1:0] STATUS_NONE = 2'd0;
	localparam logic [1:0] STATUS_OK = 2'd1;
	localparam logic [1:0] STATUS_ERR = 2'd2;

	localparam logic [6:0] RESET_ADDRESS = 7'h50;
	localparam logic [7:0] RESET_LENGTH = 8'd128;
	localparam logic [15:0] RESET_TICKS = 16'd100;

	typedef struct packed {
		logic enabled;
		logic [6:0] address;
		logic [7:0] offset;
		logic [7:0] length;
		logic [15:0] ticks;
	} cfg_t;

	typedef struct packed {
		logic scl_level;
		logic sda_pull_low;
		logic byte_valid;
		logic [7:0] byte_data;
		logic [6:0] byte_index;
		logic busy_res;
		logic [1:0] status;
	} result_t;

endpackage

/* hdl/ddc_edid_cfg.sv */
// configuration registers of the ddc edid reader
module ddc_edid_cfg (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [2:0] wr_index,
	input logic [15:0] wr_data,
	output ddc_edid_pkg::cfg_t cfg
);
	import ddc_edid_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled <= 1'b0;
			cfg_q.address <= RESET_ADDRESS;
			cfg_q.offset <= 8'd0;
			cfg_q.length <= RESET_LENGTH;
			cfg_q.ticks <= RESET_TICKS;
		end else if (wr_en) begin
			case (wr_index)
				REG_ENABLE: cfg_q.enabled <= wr_data[0];
				REG_ADDRESS: cfg_q.address <= wr_data[6:0];
				REG_OFFSET: cfg_q.offset <= wr_data[7:0];
				REG_LENGTH: cfg_q.length <= wr_data[7:0];
				REG_TICKS: cfg_q.ticks <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/ddc_edid_seq.sv */
// bus phase sequencer: timer, shifter and byte counter
module ddc_edid_seq (
	input logic clk,
	input logic arst_n,
	input logic step,
	input logic kind,
	input logic sda_level,
	input ddc_edid_pkg::cfg_t cfg,
	output ddc_edid_pkg::result_t res
);
	import ddc_edid_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_ST_A, PH_ST_B, PH_ST_C, PH_TX_LO, PH_TX_HI, PH_TA_LO, PH_TA_HI,
		PH_RS, PH_RX_LO, PH_RX_HI, PH_RA_LO, PH_RA_HI, PH_SP_A, PH_SP_B, PH_SP_C
	} phase_t;

	phase_t ph_q, ph_d;
	logic [15:0] tick_q, tick_d;
	logic [3:0] bit_q, bit_d;
	logic [7:0] byte_q, byte_d;
	logic [7:0] shift_q, shift_d;
	logic err_q, err_d;

	logic [EFF_W-1:0] eff_len;
	logic [16:0] tick_inc;
	logic [16:0] limit;
	logic [3:0] bit_inc;
	logic [7:0] byte_inc;
	logic [7:0] shift_rx;
	logic last_next;
	logic [7:0] tx_addr_w;
	logic [7:0] tx_addr_r;

	always_comb begin
		if (cfg.length == 8'd0) begin
			eff_len = EFF_W'(1);
		end else if ({1'b0, cfg.length} > 9'(MAX_BYTES)) begin
			eff_len = EFF_W'(MAX_BYTES);
		end else begin
			eff_len = EFF_W'(cfg.length);
		end
	end

	assign tick_inc = {1'b0, tick_q} + 17'd1;
	assign limit = (cfg.ticks == 16'd0) ? 17'd1 : {1'b0, cfg.ticks};
	assign bit_inc = bit_q + 4'd1;
	assign byte_inc = byte_q + 8'd1;
	assign shift_rx = {shift_q[6:0], sda_level};
	assign tx_addr_w = {cfg.address, 1'b0};
	assign tx_addr_r = {cfg.address, 1'b1};

	always_comb begin
		ph_d = ph_q;
		tick_d = tick_q;
		bit_d = bit_q;
		byte_d = byte_q;
		shift_d = shift_q;
		err_d = err_q;
		res.scl_level = 1'b1;
		res.sda_pull_low = 1'b0;
		res.byte_valid = 1'b0;
		res.byte_data = 8'd0;
		res.byte_index = 7'd0;
		res.status = STATUS_NONE;
		if (kind) begin
			if (ph_q == PH_IDLE) begin
				if (!cfg.enabled) begin
					res.status = STATUS_ERR;
				end else begin
					ph_d = PH_ST_A;
					tick_d = 16'd0;
					bit_d = 4'd0;
					byte_d = 8'd0;
					shift_d = 8'd0;
					err_d = 1'b0;
				end
			end
		end else if (ph_q != PH_IDLE) begin
			if (tick_inc < limit) begin
				tick_d = tick_inc[15:0];
			end else begin
				tick_d = 16'd0;
				case (ph_q)
					PH_ST_A: ph_d = PH_ST_B;
					PH_ST_B: ph_d = PH_ST_C;
					PH_ST_C: begin
						if (byte_q == 8'd1) begin
							shift_d = cfg.offset;
						end else if (byte_q == 8'd2) begin
							shift_d = tx_addr_r;
						end else begin
							shift_d = tx_addr_w;
						end
						bit_d = 4'd0;
						ph_d = PH_TX_LO;
					end
					PH_TX_LO: ph_d = PH_TX_HI;
					PH_TX_HI: begin
						shift_d = {shift_q[6:0], 1'b0};
						if (bit_inc[3]) begin
							bit_d = 4'd0;
							ph_d = PH_TA_LO;
						end else begin
							bit_d = bit_inc;
							ph_d = PH_TX_LO;
						end
					end
					PH_TA_LO: ph_d = PH_TA_HI;
					PH_TA_HI: begin
						if (sda_level) begin
							err_d = 1'b1;
							ph_d = PH_SP_A;
						end else if (byte_q == 8'd0) begin
							byte_d = 8'd1;
							shift_d = cfg.offset;
							bit_d = 4'd0;
							ph_d = PH_TX_LO;
						end else if (byte_q == 8'd1) begin
							byte_d = 8'd2;
							ph_d = PH_RS;
						end else begin
							byte_d = 8'd0;
							bit_d = 4'd0;
							shift_d = 8'd0;
							ph_d = PH_RX_LO;
						end
					end
					PH_RS: ph_d = PH_ST_A;
					PH_RX_LO: ph_d = PH_RX_HI;
					PH_RX_HI: begin
						shift_d = shift_rx;
						if (bit_inc[3]) begin
							res.byte_valid = 1'b1;
							res.byte_data = shift_rx;
							res.byte_index = byte_q[6:0];
							bit_d = 4'd0;
							ph_d = PH_RA_LO;
						end else begin
							bit_d = bit_inc;
							ph_d = PH_RX_LO;
						end
					end
					PH_RA_LO: ph_d = PH_RA_HI;
					PH_RA_HI: begin
						byte_d = byte_inc;
						if ({1'b0, byte_inc} >= 9'(eff_len) || byte_inc == 8'd0) begin
							ph_d = PH_SP_A;
						end else begin
							shift_d = 8'd0;
							ph_d = PH_RX_LO;
						end
					end
					PH_SP_A: ph_d = PH_SP_B;
					PH_SP_B: ph_d = PH_SP_C;
					PH_SP_C: begin
						res.status = err_q ? STATUS_ERR : STATUS_OK;
						ph_d = PH_IDLE;
						bit_d = 4'd0;
						byte_d = 8'd0;
						shift_d = 8'd0;
						err_d = 1'b0;
					end
					default: ph_d = PH_IDLE;
				endcase
			end
		end

		// line levels follow the phase after this step
		last_next = ({1'b0, byte_d} + 9'd1) >= 9'(eff_len);
		case (ph_d)
			PH_ST_B: res.sda_pull_low = 1'b1;
			PH_ST_C, PH_SP_A: begin
				res.scl_level = 1'b0;
				res.sda_pull_low = 1'b1;
			end
			PH_TX_LO: begin
				res.scl_level = 1'b0;
				res.sda_pull_low = !shift_d[7];
			end
			PH_TX_HI: res.sda_pull_low = !shift_d[7];
			PH_TA_LO, PH_RS, PH_RX_LO: res.scl_level = 1'b0;
			PH_RA_LO: begin
				res.scl_level = 1'b0;
				res.sda_pull_low = !last_next;
			end
			PH_RA_HI: res.sda_pull_low = !last_next;
			PH_SP_B: res.sda_pull_low = 1'b1;
			default: ;
		endcase
		res.busy_res = (ph_d != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			tick_q <= 16'd0;
			bit_q <= 4'd0;
			byte_q <= 8'd0;
			shift_q <= 8'd0;
			err_q <= 1'b0;
		end else if (step) begin
			ph_q <= ph_d;
			tick_q <= tick_d;
			bit_q <= bit_d;
			byte_q <= byte_d;
			shift_q <= shift_d;
			err_q <= err_d;
		end
	end

endmodule

/* hdl/ddc_edid_i2c_reader_unit.sv */
// top level of the ddc edid reader: handshakes, config port and result register
//
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    kind, sda_level
// out       output     out_valid/out_ready  scl_level .. status
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one input transfer per cycle while in_ready is high; its result appears in the output register
// on the next cycle, set by the single sequencer step between the registers
// in_ready is high whenever the result register is empty or being drained
// cfg_ready is always high; reset puts the sequencer in idle and clears out_valid
module ddc_edid_i2c_reader_unit (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic kind,
	input logic sda_level,
	output logic out_valid,
	input logic out_ready,
	output logic scl_level,
	output logic sda_pull_low,
	output logic byte_valid,
	output logic [7:0] byte_data,
	output logic [6:0] byte_index,
	output logic busy_res,
	output logic [1:0] status,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [2:0] cfg_index,
	input logic [15:0] cfg_data
);
	import ddc_edid_pkg::*;

	cfg_t cfg;
	result_t res;
	result_t res_q;
	logic out_valid_q;
	logic accept;

	assign cfg_ready = 1'b1;
	assign in_ready = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	ddc_edid_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cfg_valid && cfg_ready),
		.wr_index(cfg_index),
		.wr_data(cfg_data),
		.cfg(cfg)
	);

	ddc_edid_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.step(accept),
		.kind(kind),
		.sda_level(sda_level),
		.cfg(cfg),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign scl_level = res_q.scl_level;
	assign sda_pull_low = res_q.sda_pull_low;
	assign byte_valid = res_q.byte_valid;
	assign byte_data = res_q.byte_data;
	assign byte_index = res_q.byte_index;
	assign busy_res = res_q.busy_res;
	assign status = res_q.status;

endmodule

/* hdl/ddc_edid_chk.sv */
// port checker of the ddc edid reader and its bind
`include "ddc_edid_i2c_reader_unit_assert.svh"

module ddc_edid_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic byte_valid,
	input logic busy_res,
	input logic [1:0] status
);
	import ddc_edid_pkg::*;

	`DDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))
	`DDC_ASSERT_IMPL(a_no_overrun, out_valid && !out_ready, !in_ready)
	`DDC_ASSERT_IMPL(a_byte_busy, out_valid && byte_valid, busy_res && status == STATUS_NONE)
	`DDC_ASSERT_IMPL(a_status_idle, out_valid && status != STATUS_NONE, !busy_res && status <= STATUS_ERR)
	`DDC_ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid)
endmodule

bind ddc_edid_i2c_reader_unit ddc_edid_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.byte_valid(byte_valid),
	.busy_res(busy_res),
	.status(status)
);
